FILE: sv/drn_pkg.sv
// Shared constants, types and digit pattern functions for the Roman numeral unit.
`timescale 1ns / 1ps

package drn_pkg;

    localparam int NUM_W     = 12;
    localparam int GLYPH_W   = 7;
    localparam int DIGITS    = 4;
    localparam int BIT_CNT_W = 4;

    localparam logic [NUM_W-1:0]     TOP_VALUE = 12'd3999;
    localparam logic [BIT_CNT_W-1:0] NUM_BITS  = 4'd12;

    localparam logic [GLYPH_W-1:0] ASCII_I = 7'd73;
    localparam logic [GLYPH_W-1:0] ASCII_V = 7'd86;
    localparam logic [GLYPH_W-1:0] ASCII_X = 7'd88;
    localparam logic [GLYPH_W-1:0] ASCII_L = 7'd76;
    localparam logic [GLYPH_W-1:0] ASCII_C = 7'd67;
    localparam logic [GLYPH_W-1:0] ASCII_D = 7'd68;
    localparam logic [GLYPH_W-1:0] ASCII_M = 7'd77;

    // Letter roles within one decimal place.
    localparam logic [1:0] SYM_ONE  = 2'd0;
    localparam logic [1:0] SYM_FIVE = 2'd1;
    localparam logic [1:0] SYM_TEN  = 2'd2;

    typedef logic [DIGITS-1:0][3:0] bcd_digits_t;

    typedef struct packed {
        logic        done;
        bcd_digits_t digits;
    } bcd_result_t;

    // Number of letters that one decimal digit produces.
    function automatic logic [2:0] shape_len(input logic [3:0] d);
        logic [2:0] len;
        unique case (d)
            4'd0:    len = 3'd0;
            4'd1:    len = 3'd1;
            4'd2:    len = 3'd2;
            4'd3:    len = 3'd3;
            4'd4:    len = 3'd2;
            4'd5:    len = 3'd1;
            4'd6:    len = 3'd2;
            4'd7:    len = 3'd3;
            4'd8:    len = 3'd4;
            4'd9:    len = 3'd2;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    // Role of the letter at a given position within a digit's pattern.
    function automatic logic [1:0] shape_sym(input logic [3:0] d, input logic [1:0] step);
        logic [1:0] sym;
        unique case (d)
            4'd4:                sym = (step == 2'd0) ? SYM_ONE : SYM_FIVE;
            4'd5:                sym = SYM_FIVE;
            4'd6, 4'd7, 4'd8:    sym = (step == 2'd0) ? SYM_FIVE : SYM_ONE;
            4'd9:                sym = (step == 2'd0) ? SYM_ONE : SYM_TEN;
            default:             sym = SYM_ONE;
        endcase
        return sym;
    endfunction

    // ASCII letter for a role at a decimal place, ones place first.
    function automatic logic [GLYPH_W-1:0] place_letter(input logic [1:0] place,
                                                        input logic [1:0] sym);
        logic [GLYPH_W-1:0] ch;
        unique case (place)
            2'd0:    ch = (sym == SYM_ONE) ? ASCII_I : (sym == SYM_FIVE) ? ASCII_V : ASCII_X;
            2'd1:    ch = (sym == SYM_ONE) ? ASCII_X : (sym == SYM_FIVE) ? ASCII_L : ASCII_C;
            2'd2:    ch = (sym == SYM_ONE) ? ASCII_C : (sym == SYM_FIVE) ? ASCII_D : ASCII_M;
            default: ch = ASCII_M;
        endcase
        return ch;
    endfunction

endpackage

FILE: sv/drn_bcd.sv
// Bit-serial binary to BCD converter using the shift and add-three method.
`timescale 1ns / 1ps

module drn_bcd (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [drn_pkg::NUM_W-1:0]    number,
    output logic                         busy,
    output drn_pkg::bcd_result_t         result
);

    logic [drn_pkg::NUM_W-1:0]     bin_reg, bin_next;
    drn_pkg::bcd_digits_t          bcd_reg, bcd_next;
    logic [drn_pkg::BIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    drn_pkg::bcd_digits_t          corr;
    logic                          done;

    // Each digit of five or more gets three added before the shift.
    always_comb
    begin
        for (int i = 0; i < drn_pkg::DIGITS; i++)
        begin
            corr[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    assign done = busy_reg && (cnt_reg == '0);

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            bin_next  = number;
            bcd_next  = '0;
            cnt_next  = drn_pkg::NUM_BITS;
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            bcd_next = {corr[3][2:0], corr[2], corr[1], corr[0], bin_reg[drn_pkg::NUM_W-1]};
            bin_next = {bin_reg[drn_pkg::NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign busy          = busy_reg;
    assign result.done   = done;
    assign result.digits = bcd_reg;

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("conversion started while one was running");

    a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && $past(busy_reg) |-> bcd_reg[0] <= 4'd9 && bcd_reg[1] <= 4'd9
                                        && bcd_reg[2] <= 4'd9 && bcd_reg[3] <= 4'd9)
        else $error("BCD digit out of decimal range");

    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy_reg)
        else $error("converter still busy after finishing");

endmodule

FILE: sv/drn_emit.sv
// Letter sequencer: walks the BCD digits and presents one numeral letter per cycle while the output is not stalled.
`timescale 1ns / 1ps

module drn_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  drn_pkg::bcd_result_t          load,
    output logic                          busy,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [drn_pkg::GLYPH_W-1:0]   glyph,
    output logic                          final_glyph
);

    drn_pkg::bcd_digits_t          dig_reg, dig_next;
    logic [1:0]                    place_reg, place_next;
    logic [1:0]                    step_reg, step_next;
    logic                          run_reg, run_next;
    logic                          out_valid_reg, out_valid_next;
    logic [drn_pkg::GLYPH_W-1:0]   glyph_reg, glyph_next;
    logic                          final_reg, final_next;

    logic [3:0] cur_digit;
    logic [2:0] len;
    logic [1:0] sym;
    logic       has_glyph;
    logic       last_step;
    logic       lower_zero;
    logic       advance;
    logic       is_final;

    assign cur_digit = dig_reg[place_reg];
    assign len       = drn_pkg::shape_len(cur_digit);
    assign sym       = drn_pkg::shape_sym(cur_digit, step_reg);
    assign has_glyph = (len != 3'd0);
    assign last_step = ({1'b0, step_reg} + 3'd1) == len;
    assign advance   = run_reg && (!out_valid_reg || out_ready);
    assign is_final  = has_glyph && last_step && lower_zero;

    always_comb
    begin
        unique case (place_reg)
            2'd3:    lower_zero = (dig_reg[2:0] == '0);
            2'd2:    lower_zero = (dig_reg[1:0] == '0);
            2'd1:    lower_zero = (dig_reg[0] == '0);
            default: lower_zero = 1'b1;
        endcase
    end

    always_comb
    begin
        dig_next       = dig_reg;
        place_next     = place_reg;
        step_next      = step_reg;
        run_next       = run_reg;
        out_valid_next = out_valid_reg;
        glyph_next     = glyph_reg;
        final_next     = final_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (load.done)
        begin
            dig_next   = load.digits;
            place_next = 2'd3;
            step_next  = 2'd0;
            run_next   = 1'b1;
        end
        else if (advance)
        begin
            if (has_glyph)
            begin
                out_valid_next = 1'b1;
                glyph_next     = drn_pkg::place_letter(place_reg, sym);
                final_next     = is_final;
                if (is_final || (last_step && place_reg == 2'd0))
                begin
                    run_next = 1'b0;
                end
                else if (last_step)
                begin
                    place_next = place_reg - 2'd1;
                    step_next  = 2'd0;
                end
                else
                begin
                    step_next = step_reg + 2'd1;
                end
            end
            else if (place_reg == 2'd0)
            begin
                run_next = 1'b0;
            end
            else
            begin
                place_next = place_reg - 2'd1;
                step_next  = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg   <= dig_next;
        place_reg <= place_next;
        step_reg  <= step_next;
        glyph_reg <= glyph_next;
        final_reg <= final_next;
    end

    assign busy        = run_reg;
    assign out_valid   = out_valid_reg;
    assign glyph       = glyph_reg;
    assign final_glyph = final_reg;

    a_load_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load.done |-> !run_reg)
        else $error("digits loaded while a numeral was still being sent");

    a_letter_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> glyph_reg == drn_pkg::ASCII_I || glyph_reg == drn_pkg::ASCII_V
                       || glyph_reg == drn_pkg::ASCII_X || glyph_reg == drn_pkg::ASCII_L
                       || glyph_reg == drn_pkg::ASCII_C || glyph_reg == drn_pkg::ASCII_D
                       || glyph_reg == drn_pkg::ASCII_M)
        else $error("output letter is not a numeral letter");

    a_final_stops: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_final |=> !run_reg && final_reg && out_valid_reg)
        else $error("sequencer kept running after the last letter");

endmodule

FILE: sv/decimal_to_roman_numeral_unit.sv
// Top level of the integer to Roman numeral unit (values 1 to 3999).
`timescale 1ns / 1ps

// Channel   Signals                          Item
// input     in_valid / in_ready, number      one 12-bit unsigned integer
// output    out_valid / out_ready, glyph,    one ASCII numeral letter, with a flag
//           final_glyph                      on the last letter of the numeral
//
// An accepted item in range goes through twelve shift steps in the serial BCD converter and
// a hand-over to the sequencer, which then steps through the letters one at a time and also
// passes over zero digits. Items that are zero or above 3999 are accepted and dropped. A new
// item is taken once the sequencer has loaded its last letter into the output register, even
// while that letter still waits. A stall on the output holds the sequencer; reset clears all
// control state at once.

module decimal_to_roman_numeral_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [drn_pkg::NUM_W-1:0]     number,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [drn_pkg::GLYPH_W-1:0]   glyph,
    output logic                          final_glyph
);

    logic                 bcd_busy;
    logic                 emit_busy;
    logic                 in_range;
    logic                 start;
    drn_pkg::bcd_result_t bcd_result;

    // The block works on one item at a time: input is taken only when both the
    // converter and the sequencer have finished with the previous item.
    assign in_ready = !bcd_busy && !emit_busy;
    assign in_range = (number != '0) && (number <= drn_pkg::TOP_VALUE);
    assign start    = in_valid && in_ready && in_range;

    drn_bcd u_bcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .number (number),
        .busy   (bcd_busy),
        .result (bcd_result)
    );

    drn_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (bcd_result),
        .busy        (emit_busy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .glyph       (glyph),
        .final_glyph (final_glyph)
    );

    a_one_stage_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(bcd_busy && emit_busy))
        else $error("converter and sequencer busy at the same time");

    a_drop_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_range |=> in_ready)
        else $error("out-of-range item started a conversion");

    a_convert_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> bcd_busy && !in_ready)
        else $error("in-range item did not start a conversion");

endmodule

FILE: test/decimal_to_roman_numeral_unit_tb.sv
// Self-checking testbench for the integer to Roman numeral unit.
`timescale 1ns / 1ps

// The bench drives numbers into the unit over the input handshake and checks every letter
// that comes out against a queue of expected letters. The expected letters come from a
// small digit-by-digit converter written here, or for a few directed rows (after reset,
// the extremes and the values that give no numeral) straight from a numeral typed into
// the stimulus table. A directed table is walked first, then random items follow.
// Both sides idle at random, and once the receiver holds off for a long stretch while the
// sender keeps offering items, so that the unit fills up and stalls its input.

module decimal_to_roman_numeral_unit_tb;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_NUMBERS = 400;
    localparam int HOLD_OFF_AT    = 150;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ROWS           = 24;

    localparam int NUM_W   = drn_pkg::NUM_W;
    localparam int GLYPH_W = drn_pkg::GLYPH_W;

    localparam logic [NUM_W-1:0] TOP_VALUE = drn_pkg::TOP_VALUE;

    // Letters for one, five and ten units at each decimal place, ones place at index 0.
    localparam logic [3:0][GLYPH_W-1:0] ONE_LETTER  = {drn_pkg::ASCII_M, drn_pkg::ASCII_C,
                                                       drn_pkg::ASCII_X, drn_pkg::ASCII_I};
    localparam logic [3:0][GLYPH_W-1:0] FIVE_LETTER = {drn_pkg::ASCII_M, drn_pkg::ASCII_D,
                                                       drn_pkg::ASCII_L, drn_pkg::ASCII_V};
    localparam logic [3:0][GLYPH_W-1:0] TEN_LETTER  = {drn_pkg::ASCII_M, drn_pkg::ASCII_M,
                                                       drn_pkg::ASCII_C, drn_pkg::ASCII_X};

    typedef struct packed {
        logic [GLYPH_W-1:0] letter;
        logic               last;
    } roman_letter_t;

    typedef struct {
        logic [NUM_W-1:0] value;
        bit               typed;
        string            numeral;
    } stimulus_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [NUM_W-1:0]   number;
    logic               out_valid;
    logic               out_ready;
    logic [GLYPH_W-1:0] glyph;
    logic               final_glyph;

    roman_letter_t expected_letters[$];
    int            mismatches;
    bit            hold_off_request;

    // Rows marked typed carry their numeral; the others are worked out by the converter.
    // An empty numeral means the number lies outside 1 to 3999 and gives no letters.
    stimulus_row_t directed_rows [ROWS] = '{
        '{12'd1,    1'b1, "I"},
        '{12'd3999, 1'b1, "MMMCMXCIX"},
        '{12'd3888, 1'b1, "MMMDCCCLXXXVIII"},
        '{12'd0,    1'b1, ""},
        '{12'd4000, 1'b1, ""},
        '{12'd4095, 1'b1, ""},
        '{12'd4,    1'b0, ""},
        '{12'd9,    1'b0, ""},
        '{12'd40,   1'b0, ""},
        '{12'd90,   1'b0, ""},
        '{12'd400,  1'b0, ""},
        '{12'd900,  1'b0, ""},
        '{12'd1000, 1'b0, ""},
        '{12'd3000, 1'b0, ""},
        '{12'd1994, 1'b0, ""},
        '{12'd2468, 1'b0, ""},
        '{12'd3008, 1'b0, ""},
        '{12'd1111, 1'b0, ""},
        '{12'd505,  1'b0, ""},
        '{12'd60,   1'b0, ""},
        '{12'd7,    1'b0, ""},
        '{12'd444,  1'b0, ""},
        '{12'd2049, 1'b0, ""},
        '{12'd2730, 1'b0, ""}
    };

    decimal_to_roman_numeral_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .number      (number),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .glyph       (glyph),
        .final_glyph (final_glyph)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Converts one number digit by digit, thousands first, and queues its letters. Digits
    // of four and nine take the subtractive forms; five to eight lead with the five letter.
    task automatic queue_roman_letters(input logic [NUM_W-1:0] value);
        int                 remaining;
        int                 digit [4];
        int                 d;
        logic [GLYPH_W-1:0] spelled [$];
        roman_letter_t      entry;
        if (value == '0 || value > TOP_VALUE)
            return;
        remaining = int'(value);
        for (int p = 0; p < 4; p++)
        begin
            digit[p]  = remaining % 10;
            remaining = remaining / 10;
        end
        for (int p = 3; p >= 0; p--)
        begin
            d = digit[p];
            case (d)
                4:
                begin
                    spelled.push_back(ONE_LETTER[p]);
                    spelled.push_back(FIVE_LETTER[p]);
                end
                9:
                begin
                    spelled.push_back(ONE_LETTER[p]);
                    spelled.push_back(TEN_LETTER[p]);
                end
                default:
                begin
                    if (d >= 5)
                        spelled.push_back(FIVE_LETTER[p]);
                    for (int k = 0; k < d % 5; k++)
                        spelled.push_back(ONE_LETTER[p]);
                end
            endcase
        end
        foreach (spelled[k])
        begin
            entry.letter = spelled[k];
            entry.last   = (k == spelled.size() - 1);
            expected_letters.push_back(entry);
        end
    endtask

    task automatic queue_typed_numeral(input string numeral);
        roman_letter_t entry;
        for (int k = 0; k < numeral.len(); k++)
        begin
            entry.letter = GLYPH_W'(numeral[k]);
            entry.last   = (k == numeral.len() - 1);
            expected_letters.push_back(entry);
        end
    endtask

    // Idle stretch length: mostly none or short, now and then long.
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // Random number: mostly in range with a bias towards short and long numerals, and a
    // share of zero and of values above 3999, which the unit drops.
    function automatic logic [NUM_W-1:0] random_number();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return '0;
        else if (roll < 12)
            return NUM_W'($urandom_range(4000, 4095));
        else if (roll < 30)
            return NUM_W'($urandom_range(1, 99));
        else if (roll < 42)
            return NUM_W'($urandom_range(3000, 3999));
        else
            return NUM_W'($urandom_range(1, 3999));
    endfunction

    // Offers one item after an optional gap and waits for it to be taken. The expected
    // letters are queued at the accepting edge. Valid is left high on return, so that the
    // next call either lowers it for a gap or replaces the payload in a single assignment.
    task automatic offer_number(input logic [NUM_W-1:0] value, input bit typed,
                                input string numeral, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : idle_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        number   <= value;
        do
            @(posedge clk);
        while (!in_ready);
        if (typed)
            queue_typed_numeral(numeral);
        else
            queue_roman_letters(value);
    endtask

    // Sender: reset, the directed table, then random items, out-of-range ones mixed in.
    initial
    begin
        int               offered;
        logic [NUM_W-1:0] value;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        number           = '0;
        mismatches       = 0;
        hold_off_request = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            offer_number(directed_rows[r].value, directed_rows[r].typed,
                         directed_rows[r].numeral, 1'b0);

        offered = 0;
        while (offered < RANDOM_NUMBERS)
        begin
            value = random_number();
            // Ask the receiver for its long hold-off once, part way through.
            if (offered == HOLD_OFF_AT)
                hold_off_request = 1'b1;
            // Every fourth block of fifty items goes back to back.
            offer_number(value, 1'b0, "", ((offered / 50) % 4) == 3);
            offered++;
        end
        in_valid <= 1'b0;

        // Drain, then give the unit time to show any letter that it should not produce.
        while (expected_letters.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_letters.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Receiver: runs of ready broken by stalls, plus the one long hold-off on request.
    initial
    begin
        int run;
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge clk);
            end
            run = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 20);
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = idle_length();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Checks every letter taken from the unit against the oldest expected letter.
    always @(posedge clk)
    begin
        roman_letter_t wanted;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_letters.size() == 0)
            begin
                $error("glyph: no letter expected, got %0d", glyph);
                mismatches++;
            end
            else
            begin
                wanted = expected_letters.pop_front();
                if (glyph !== wanted.letter)
                begin
                    $error("glyph: expected %0d, got %0d", wanted.letter, glyph);
                    mismatches++;
                end
                if (final_glyph !== wanted.last)
                begin
                    $error("final_glyph: expected %0d, got %0d", wanted.last, final_glyph);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: ends the run if neither side moves an item for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
sv/drn_pkg.sv
sv/drn_bcd.sv
sv/drn_emit.sv
sv/decimal_to_roman_numeral_unit.sv
test/decimal_to_roman_numeral_unit_tb.sv
